>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/jsu_pkg.sv
// Shared types, constants and helper functions of the JSON string unescaper.
`default_nettype none

package jsu_pkg;

  // Default depth of the request queue between parser and emitter
  localparam int QUEUE_DEPTH = 4;

  // Character codes the parser looks for
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_STR     = 3'd1,
    PH_ESC     = 3'd2,
    PH_HEX1    = 3'd3,
    PH_PAIR_BS = 3'd4,
    PH_PAIR_U  = 3'd5,
    PH_HEX2    = 3'd6
  } phase_t;

  // One request: up to four result bytes, index of the last one, and its kind
  typedef struct packed {
    kind_t            kind;
    logic [1:0]       nlast;
    logic [3:0][7:0]  bytes;
  } req_t;

  // Request with a single result
  function automatic req_t mk_one(input logic [7:0] b, input kind_t k);
    req_t r;
    r.kind     = k;
    r.nlast    = 2'd0;
    r.bytes    = '0;
    r.bytes[0] = b;
    return r;
  endfunction

  // Hex digit decode: bit 4 set when the byte is a hex digit, low bits its value
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, 4'(b[3:0] + 4'd9)};
    end
    return r;
  endfunction

  // UTF-8 encoding of a code point up to 0x10FFFF
  function automatic req_t utf8_encode(input logic [20:0] cp);
    req_t r;
    r.kind  = KIND_DATA;
    r.nlast = 2'd0;
    r.bytes = '0;
    if (cp[20:7] == 14'd0) begin
      r.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp[20:11] == 10'd0) begin
      r.nlast    = 2'd1;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp[20:16] == 5'd0) begin
      r.nlast    = 2'd2;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.nlast    = 2'd3;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/jsu_front.sv
// Parser: accepts input bytes, tracks escapes and surrogates, pushes requests.
`default_nettype none

module jsu_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_ready,
  input  wire  [7:0]          in_byte,
  output logic                push,
  output jsu_pkg::req_t       push_req
);

`include "assert_macros.svh"

  jsu_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [11:0]     acc_r, acc_nxt;
  logic [9:0]      hs_r, hs_nxt;

  logic            accept;
  logic            err;
  logic [4:0]      nib;
  logic [15:0]     code;
  logic [10:0]     pair_hi;

  assign accept  = in_valid && in_ready;
  assign nib     = jsu_pkg::hex_nibble(in_byte);
  assign code    = {acc_r, nib[3:0]};
  // 0x10000 + (high << 10) puts high + 0x40 above the low ten bits
  assign pair_hi = {1'b0, hs_r} + 11'd64;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= jsu_pkg::PH_IDLE;
      cnt_r   <= 2'd0;
      acc_r   <= 12'd0;
      hs_r    <= 10'd0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      hs_r    <= hs_nxt;
    end
  end

  // Next state and request
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    hs_nxt    = hs_r;
    push      = 1'b0;
    err       = 1'b0;
    push_req  = jsu_pkg::mk_one(8'h00, jsu_pkg::KIND_DATA);
    if (accept) begin
      unique case (phase_r)
        jsu_pkg::PH_STR: begin
          if (in_byte == jsu_pkg::CH_QUOTE) begin
            push      = 1'b1;
            push_req  = jsu_pkg::mk_one(8'h00, jsu_pkg::KIND_END);
            phase_nxt = jsu_pkg::PH_IDLE;
            cnt_nxt   = 2'd0;
            acc_nxt   = 12'd0;
            hs_nxt    = 10'd0;
          end else if (in_byte < jsu_pkg::CH_SPACE) begin
            err = 1'b1;
          end else if (in_byte == jsu_pkg::CH_BSLASH) begin
            phase_nxt = jsu_pkg::PH_ESC;
          end else begin
            push     = 1'b1;
            push_req = jsu_pkg::mk_one(in_byte, jsu_pkg::KIND_DATA);
          end
        end
        jsu_pkg::PH_ESC: begin
          phase_nxt = jsu_pkg::PH_STR;
          push      = 1'b1;
          unique case (in_byte)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
              push_req = jsu_pkg::mk_one(in_byte, jsu_pkg::KIND_DATA);
            jsu_pkg::CH_B: push_req = jsu_pkg::mk_one(8'h08, jsu_pkg::KIND_DATA);
            jsu_pkg::CH_F: push_req = jsu_pkg::mk_one(8'h0C, jsu_pkg::KIND_DATA);
            jsu_pkg::CH_N: push_req = jsu_pkg::mk_one(8'h0A, jsu_pkg::KIND_DATA);
            jsu_pkg::CH_R: push_req = jsu_pkg::mk_one(8'h0D, jsu_pkg::KIND_DATA);
            jsu_pkg::CH_T: push_req = jsu_pkg::mk_one(8'h09, jsu_pkg::KIND_DATA);
            jsu_pkg::CH_U: begin
              push      = 1'b0;
              phase_nxt = jsu_pkg::PH_HEX1;
              cnt_nxt   = 2'd0;
              acc_nxt   = 12'd0;
            end
            default: begin
              push = 1'b0;
              err  = 1'b1;
            end
          endcase
        end
        jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
          if (!nib[4]) begin
            err = 1'b1;
          end else if (cnt_r != 2'd3) begin
            cnt_nxt = cnt_r + 2'd1;
            acc_nxt = {acc_r[7:0], nib[3:0]};
          end else begin
            cnt_nxt = 2'd0;
            acc_nxt = 12'd0;
            if (phase_r == jsu_pkg::PH_HEX1) begin
              // Surrogate range: high half waits for its partner, low half alone fails
              if (code[15:11] == 5'b11011) begin
                if (!code[10]) begin
                  hs_nxt    = code[9:0];
                  phase_nxt = jsu_pkg::PH_PAIR_BS;
                end else begin
                  err = 1'b1;
                end
              end else begin
                phase_nxt = jsu_pkg::PH_STR;
                push      = 1'b1;
                push_req  = jsu_pkg::utf8_encode({5'd0, code});
              end
            end else begin
              if (code[15:10] != 6'b110111) begin
                err = 1'b1;
              end else begin
                hs_nxt    = 10'd0;
                phase_nxt = jsu_pkg::PH_STR;
                push      = 1'b1;
                push_req  = jsu_pkg::utf8_encode({pair_hi[10:0], code[9:0]});
              end
            end
          end
        end
        jsu_pkg::PH_PAIR_BS: begin
          if (in_byte != jsu_pkg::CH_BSLASH) begin
            err = 1'b1;
          end else begin
            phase_nxt = jsu_pkg::PH_PAIR_U;
          end
        end
        jsu_pkg::PH_PAIR_U: begin
          if (in_byte != jsu_pkg::CH_U) begin
            err = 1'b1;
          end else begin
            phase_nxt = jsu_pkg::PH_HEX2;
            cnt_nxt   = 2'd0;
            acc_nxt   = 12'd0;
          end
        end
        default: begin
          // Idle: only an opening quote starts a string
          if (in_byte != jsu_pkg::CH_QUOTE) begin
            err = 1'b1;
          end else begin
            phase_nxt = jsu_pkg::PH_STR;
            cnt_nxt   = 2'd0;
            acc_nxt   = 12'd0;
            hs_nxt    = 10'd0;
          end
        end
      endcase
      // Any syntax error reports once and drops back to idle
      if (err) begin
        push      = 1'b1;
        push_req  = jsu_pkg::mk_one(8'h00, jsu_pkg::KIND_ERR);
        phase_nxt = jsu_pkg::PH_IDLE;
        cnt_nxt   = 2'd0;
        acc_nxt   = 12'd0;
        hs_nxt    = 10'd0;
      end
    end
  end

  // End and error requests always leave the parser idle with cleared scratch state
  `ASSERT_NXT(a_front_end_idle, clk, rst_n, push && push_req.kind != jsu_pkg::KIND_DATA, phase_r == jsu_pkg::PH_IDLE && hs_r == 10'd0 && cnt_r == 2'd0, "end or error did not return parser to idle")

endmodule

`default_nettype wire

>>> rtl/jsu_queue.sv
// Small request queue between parser and emitter.
`default_nettype none

module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  jsu_pkg::req_t       push_req,
  output logic                full,
  input  wire                 pop,
  output jsu_pkg::req_t       head,
  output logic                empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::req_t  mem_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill count update, wrapping at any depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

`default_nettype wire

>>> rtl/jsu_back.sv
// Emitter: serializes each queued request into results through an output register.
`default_nettype none

module jsu_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  jsu_pkg::req_t       head,
  input  wire                 empty,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [7:0]          out_byte,
  output logic [1:0]          out_kind,
  output logic                out_last
);

`include "assert_macros.svh"

  logic            valid_r, valid_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [7:0]      byte_r;
  jsu_pkg::kind_t  kind_r;
  logic            last_r;

  logic            load;
  logic            at_last;

  // Load the output register whenever the queue holds a request and the register is free or being drained
  assign load    = !empty && (!valid_r || out_ready);
  assign at_last = (idx_r == head.nlast);
  assign pop     = load && at_last;

  always_comb begin
    valid_nxt = load || (valid_r && !out_ready);
    idx_nxt   = idx_r;
    if (load) begin
      idx_nxt = at_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.bytes[idx_r];
      kind_r <= head.kind;
      last_r <= at_last;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;

  // A stalled result keeps the byte position within its request
  `ASSERT_NXT(a_back_idx_hold, clk, rst_n, valid_r && !out_ready, $stable(idx_r), "byte index moved during output stall")

endmodule

`default_nettype wire

>>> rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper: parser, request queue and emitter.
//
//  channel | dir | ports                         | contents
//  --------+-----+-------------------------------+-------------------------------------
//  in      | in  | in_tvalid/in_tready/in_tdata  | one byte of quoted JSON text
//  out     | out | out_tvalid/out_tready/out_*   | decoded byte, kind, last of run
//
// Bytes that cause no result only move the parser. A request of n results is
// emitted one result per cycle while out_tready is high; a four-byte UTF-8
// sequence gives four results. A result is registered in the request queue and
// then in the output register. Input stalls only when the request queue is full.
// Reset (rst_n low, synchronous) returns the parser to idle and empties the queue.
`default_nettype none

module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [1:0]  out_tuser,  // [1:0] out_kind
  output logic        out_tlast   // last_of_run
);

`include "assert_macros.svh"

  logic           q_push;
  jsu_pkg::req_t  q_push_req;
  logic           q_full;
  logic           q_pop;
  jsu_pkg::req_t  q_head;
  logic           q_empty;

  assign in_tready = !q_full;

  // Parser
  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .push     (q_push),
    .push_req (q_push_req)
  );

  // Request queue
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (q_push_req),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Emitter
  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_kind  (out_tuser),
    .out_last  (out_tlast)
  );

  // End and error results stand alone and carry a zero byte
  `ASSERT_IMP(a_top_ctrl_result, clk, rst_n, out_tvalid && out_tuser != jsu_pkg::KIND_DATA, out_tlast && out_tdata == 8'h00, "end or error result not last or not zero")

  // A multi-byte run is never broken by a gap
  `ASSERT_NXT(a_top_run_gapless, clk, rst_n, out_tvalid && !out_tlast, out_tvalid, "gap inside a run of results")

endmodule

`default_nettype wire
